/* rtl/assert_macros.svh */
// assertion macros used by the checker file mss_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/mss_pkg.sv */
// types, constants and helpers for the multibyte separator splitter
// no dependencies
`default_nettype none

package mss_pkg;

   localparam int SEP_MAX_DEF = 8;
   localparam int LEN_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int SEP_W       = 64;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 64;

   // register index, taken from paddr[3]
   localparam logic CSR_IDX_LEN = 1'b0;
   localparam logic CSR_IDX_SEP = 1'b1;

   localparam logic [LEN_W-1:0] LEN_RESET = 4'd1;
   localparam logic [SEP_W-1:0] SEP_RESET = 64'd44;

   typedef enum logic [2:0] {
      WOP_HOLD,
      WOP_PASS,
      WOP_PUSH,
      WOP_PUSH_MATCH,
      WOP_PUSH_PASS
   } win_op_type;

   typedef enum logic {
      ST_ENTER,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic              full;
      logic              fills;
      logic              empty;
      logic              match;
      logic [BYTE_W-1:0] head;
   } win_stat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              field_end;
      logic              source_end;
      logic              run_last;
   } rsp_beat_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                   input logic [LEN_W-1:0] max_len);
      logic [LEN_W-1:0] len;
      len = raw;
      if (len == '0) begin
         len = LEN_W'(1);
      end
      if (len > max_len) begin
         len = max_len;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

/* rtl/mss_if.sv */
// valid/ready channel interfaces for the request and response streams
// depends on mss_pkg
`default_nettype none

interface mss_req_if;
   logic                      valid;
   logic                      ready;
   logic [mss_pkg::BYTE_W-1:0] in_byte;
   logic                      is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface mss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mss_pkg::BYTE_W-1:0] out_byte;
   logic                      has_byte;
   logic                      field_end;
   logic                      source_end;
   logic                      run_last;

   modport source (output valid, output out_byte, output has_byte, output field_end,
                   output source_end, output run_last, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input field_end,
                   input source_end, input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/multibyte_separator_splitter_core.sv */
// top level of the multibyte separator splitter
// depends on mss_pkg, mss_if, mss_csr, mss_window, mss_ctrl
//
//   channel   kind         beat
//   req_ch    valid/ready  one source byte plus end-of-source flag
//   rsp_ch    valid/ready  one field byte or one field end
//   p*        apb          separator length at 0x0, separator bytes at 0x8
//
// one request beat per cycle when the response side does not stall and no flush
// or drain runs; a byte gives at most one response beat, but a last byte passes
// out each held byte then the final end, and a lowered length drains held bytes
// first; the window register and its single result register set this pacing
// synchronous active-high reset empties the window; registers go to length 1, comma
`default_nettype none

module multibyte_separator_splitter_core #(
   parameter int SEP_MAX = mss_pkg::SEP_MAX_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mss_req_if.sink                          req_ch,
   mss_rsp_if.source                        rsp_ch,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [mss_pkg::PADDR_W-1:0] paddr,
   input  wire logic [mss_pkg::PDATA_W-1:0] pwdata,
   output      logic [mss_pkg::PDATA_W-1:0] prdata,
   output      logic                        pready
);

   logic [mss_pkg::LEN_W-1:0]  act_len;
   logic [mss_pkg::SEP_W-1:0]  sep_bytes;
   logic [mss_pkg::BYTE_W-1:0] hold_byte;
   mss_pkg::win_op_type        op;
   mss_pkg::win_stat_type      stat;

   mss_csr #(.SEP_MAX(SEP_MAX)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .act_len   (act_len),
      .sep_bytes (sep_bytes)
   );

   mss_window #(.SEP_MAX(SEP_MAX)) u_window (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .in_byte   (hold_byte),
      .sep_bytes (sep_bytes),
      .act_len   (act_len),
      .stat      (stat)
   );

   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .stat      (stat),
      .op        (op),
      .hold_byte (hold_byte)
   );

endmodule

`default_nettype wire

/* rtl/mss_csr.sv */
// apb register block: separator length and separator bytes
// depends on mss_pkg
`default_nettype none

module mss_csr #(
   parameter int SEP_MAX = mss_pkg::SEP_MAX_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [mss_pkg::PADDR_W-1:0] paddr,
   input  wire logic [mss_pkg::PDATA_W-1:0] pwdata,
   output      logic [mss_pkg::PDATA_W-1:0] prdata,
   output      logic                        pready,
   output      logic [mss_pkg::LEN_W-1:0]   act_len,
   output      logic [mss_pkg::SEP_W-1:0]   sep_bytes
);

   logic [mss_pkg::LEN_W-1:0] len_ff, len_in;
   logic [mss_pkg::SEP_W-1:0] sep_ff, sep_in;
   logic                      wr;

   always_comb begin
      wr     = psel && penable && pwrite;
      len_in = len_ff;
      sep_in = sep_ff;
      if (wr && (paddr[3] == mss_pkg::CSR_IDX_LEN)) begin
         len_in = pwdata[mss_pkg::LEN_W-1:0];
      end
      if (wr && (paddr[3] == mss_pkg::CSR_IDX_SEP)) begin
         sep_in = pwdata[mss_pkg::SEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= mss_pkg::LEN_RESET;
         sep_ff <= mss_pkg::SEP_RESET;
      end else begin
         len_ff <= len_in;
         sep_ff <= sep_in;
      end
   end

   assign pready    = 1'b1;
   assign prdata    = (paddr[3] == mss_pkg::CSR_IDX_SEP) ? sep_ff
                                                         : mss_pkg::PDATA_W'(len_ff);
   assign act_len   = mss_pkg::clamp_len(len_ff, mss_pkg::LEN_W'(SEP_MAX));
   assign sep_bytes = sep_ff;

endmodule

`default_nettype wire

/* rtl/mss_window.sv */
// byte window with fill count and parallel separator compare
// depends on mss_pkg
`default_nettype none

module mss_window #(
   parameter int SEP_MAX = mss_pkg::SEP_MAX_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mss_pkg::win_op_type        op,
   input  wire logic [mss_pkg::BYTE_W-1:0] in_byte,
   input  wire logic [mss_pkg::SEP_W-1:0]  sep_bytes,
   input  wire logic [mss_pkg::LEN_W-1:0]  act_len,
   output      mss_pkg::win_stat_type      stat
);

   localparam int CNT_W = $clog2(SEP_MAX + 1);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [mss_pkg::BYTE_W-1:0] win_ff [SEP_MAX];
   logic [mss_pkg::BYTE_W-1:0] win_in [SEP_MAX];
   logic [mss_pkg::BYTE_W-1:0] pushed [SEP_MAX];
   logic [mss_pkg::BYTE_W-1:0] base   [SEP_MAX];
   logic [mss_pkg::BYTE_W-1:0] shifted[SEP_MAX];
   logic [SEP_MAX-1:0]        lane_ok;
   logic [mss_pkg::LEN_W-1:0] cnt;

   always_comb begin
      cnt = mss_pkg::LEN_W'(count_ff);
      for (int k = 0; k < SEP_MAX; k++) begin
         pushed[k]  = (CNT_W'(k) == count_ff) ? in_byte : win_ff[k];
         lane_ok[k] = (pushed[k] == sep_bytes[8*k +: 8]) ||
                      (mss_pkg::LEN_W'(k) >= act_len);
         base[k]    = (op == mss_pkg::WOP_PASS) ? win_ff[k] : pushed[k];
      end
      for (int k = 0; k < SEP_MAX; k++) begin
         if (k < SEP_MAX - 1) begin
            shifted[k] = base[k+1];
         end else begin
            shifted[k] = base[k];
         end
      end

      stat.full  = cnt >= act_len;
      stat.fills = cnt == (act_len - mss_pkg::LEN_W'(1));
      stat.empty = count_ff == '0;
      stat.match = &lane_ok;
      stat.head  = pushed[0];

      win_in   = win_ff;
      count_in = count_ff;
      case (op)
         mss_pkg::WOP_PASS: begin
            win_in   = shifted;
            count_in = count_ff - CNT_W'(1);
         end
         mss_pkg::WOP_PUSH: begin
            win_in   = pushed;
            count_in = count_ff + CNT_W'(1);
         end
         mss_pkg::WOP_PUSH_MATCH: begin
            count_in = '0;
         end
         mss_pkg::WOP_PUSH_PASS: begin
            win_in = shifted;
         end
         default: begin
            win_in   = win_ff;
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

/* rtl/mss_ctrl.sv */
// input register, step sequencer and response register
// depends on mss_pkg and mss_if
`default_nettype none

module mss_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mss_req_if.sink                          req,
   mss_rsp_if.source                        rsp,
   input  wire mss_pkg::win_stat_type       stat,
   output      mss_pkg::win_op_type         op,
   output      logic [mss_pkg::BYTE_W-1:0]  hold_byte
);

   mss_pkg::ctrl_state_type    state_ff, state_in, state_next;
   logic                       hold_valid_ff, hold_valid_in;
   logic [mss_pkg::BYTE_W-1:0] hold_byte_ff, hold_byte_in;
   logic                       hold_last_ff, hold_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mss_pkg::rsp_beat_type      beat_ff, beat_in, beat;
   mss_pkg::win_op_type        op_sel;
   logic                       emit, final_step, fire, out_free, accept;

   // step decode
   always_comb begin
      op_sel     = mss_pkg::WOP_HOLD;
      emit       = 1'b0;
      final_step = 1'b0;
      state_next = state_ff;
      beat       = '0;
      case (state_ff)
         mss_pkg::ST_ENTER: begin
            if (stat.full) begin
               op_sel        = mss_pkg::WOP_PASS;
               emit          = 1'b1;
               beat.out_byte = stat.head;
               beat.has_byte = 1'b1;
            end else begin
               final_step = !hold_last_ff;
               if (hold_last_ff) begin
                  state_next = mss_pkg::ST_FLUSH;
               end
               if (stat.fills) begin
                  emit          = 1'b1;
                  beat.run_last = !hold_last_ff;
                  if (stat.match) begin
                     op_sel         = mss_pkg::WOP_PUSH_MATCH;
                     beat.field_end = 1'b1;
                  end else begin
                     op_sel        = mss_pkg::WOP_PUSH_PASS;
                     beat.out_byte = stat.head;
                     beat.has_byte = 1'b1;
                  end
               end else begin
                  op_sel = mss_pkg::WOP_PUSH;
               end
            end
         end
         mss_pkg::ST_FLUSH: begin
            emit = 1'b1;
            if (!stat.empty) begin
               op_sel        = mss_pkg::WOP_PASS;
               beat.out_byte = stat.head;
               beat.has_byte = 1'b1;
            end else begin
               beat.field_end  = 1'b1;
               beat.source_end = 1'b1;
               beat.run_last   = 1'b1;
               final_step      = 1'b1;
               state_next      = mss_pkg::ST_ENTER;
            end
         end
         default: begin
            state_next = mss_pkg::ST_ENTER;
         end
      endcase
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp.ready;
      fire      = hold_valid_ff && (!emit || out_free);
      op        = fire ? op_sel : mss_pkg::WOP_HOLD;
      state_in  = fire ? state_next : state_ff;
      req.ready = !hold_valid_ff || (fire && final_step);
      accept    = req.valid && req.ready;

      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (fire && final_step) begin
         hold_valid_in = 1'b0;
      end
      hold_byte_in = accept ? req.in_byte : hold_byte_ff;
      hold_last_in = accept ? req.is_last : hold_last_ff;

      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
         beat_in      = beat;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mss_pkg::ST_ENTER;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_last_ff <= hold_last_in;
      beat_ff      <= beat_in;
   end

   assign hold_byte      = hold_byte_ff;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = beat_ff.out_byte;
   assign rsp.has_byte   = beat_ff.has_byte;
   assign rsp.field_end  = beat_ff.field_end;
   assign rsp.source_end = beat_ff.source_end;
   assign rsp.run_last   = beat_ff.run_last;

endmodule

`default_nettype wire

/* rtl/mss_checker.sv */
// port-level checks on the splitter response stream and request ready, bound to the top level
// depends on mss_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mss_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [mss_pkg::BYTE_W-1:0] out_byte,
   input wire logic                       has_byte,
   input wire logic                       field_end,
   input wire logic                       source_end,
   input wire logic                       run_last
);

   logic no_reset;
   assign no_reset = 1'b0;

   `MSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte) && $stable(has_byte) && $stable(run_last))
   `MSS_ASSERT_IMPLY(a_reset_quiet, clock, no_reset, $past(reset), !rsp_valid && req_ready)
   `MSS_ASSERT_IMPLY(a_end_beat, clock, reset, rsp_valid && !has_byte, field_end && (out_byte == '0))
   `MSS_ASSERT_IMPLY(a_byte_beat, clock, reset, rsp_valid && has_byte, !field_end && !source_end)
   `MSS_ASSERT_IMPLY(a_source_end, clock, reset, rsp_valid && source_end, run_last && field_end)

endmodule

bind multibyte_separator_splitter_core mss_checker u_mss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_byte   (rsp_ch.out_byte),
   .has_byte   (rsp_ch.has_byte),
   .field_end  (rsp_ch.field_end),
   .source_end (rsp_ch.source_end),
   .run_last   (rsp_ch.run_last)
);

`default_nettype wire

/* tb/sv/mss_split_checker.sv */
// scoreboard for the separator splitter: tracks the register values from the apb port,
// predicts response beats from accepted request beats and compares them in order
// depends on mss_pkg and mss_if
`default_nettype none

module mss_split_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mss_req_if                               req_mon,
   mss_rsp_if                               rsp_mon,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic                        pready,
   input  wire logic [mss_pkg::PADDR_W-1:0] paddr,
   input  wire logic [mss_pkg::PDATA_W-1:0] pwdata,
   input  wire logic [mss_pkg::PDATA_W-1:0] prdata,
   output      int                          mismatches,
   output      int                          beats_due
);
   import mss_pkg::*;

   rsp_beat_type      fields_due[$];
   logic [BYTE_W-1:0] held_bytes[SEP_MAX_DEF];
   int                held_count;
   logic [LEN_W-1:0]  sep_len;
   logic [SEP_W-1:0]  sep_bytes;

   initial begin
      mismatches = 0;
      beats_due  = 0;
   end

   function automatic void push_beat(input logic [BYTE_W-1:0] b, input logic has,
                                     input logic fend, input logic send);
      rsp_beat_type r;
      r.out_byte   = b;
      r.has_byte   = has;
      r.field_end  = fend;
      r.source_end = send;
      r.run_last   = 1'b0;
      fields_due.insert(fields_due.size(), r);
   endfunction

   function automatic void pass_oldest();
      push_beat(held_bytes[0], 1'b1, 1'b0, 1'b0);
      for (int k = 0; k < held_count - 1; k++) begin
         held_bytes[k] = held_bytes[k + 1];
      end
      held_count--;
   endfunction

   function automatic void split_byte(input logic [BYTE_W-1:0] b, input logic is_end);
      int           act;
      int           start;
      bit           hit;
      act = int'(sep_len);
      if (act == 0) begin
         act = 1;
      end
      if (act > SEP_MAX_DEF) begin
         act = SEP_MAX_DEF;
      end
      start = fields_due.size();
      // a lowered length drains the oldest bytes before the new one enters
      while (held_count >= act) begin
         pass_oldest();
      end
      held_bytes[held_count] = b;
      held_count++;
      if (held_count == act) begin
         hit = 1'b1;
         for (int k = 0; k < act; k++) begin
            if (held_bytes[k] != sep_bytes[8*k +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            held_count = 0;
            push_beat('0, 1'b0, 1'b1, 1'b0);
         end else begin
            pass_oldest();
         end
      end
      if (is_end) begin
         while (held_count > 0) begin
            pass_oldest();
         end
         push_beat('0, 1'b0, 1'b1, 1'b1);
      end
      if (fields_due.size() > start) begin
         fields_due[fields_due.size() - 1].run_last = 1'b1;
      end
   endfunction

   function automatic void check_field(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_beat_type want;
      if (reset) begin
         fields_due.delete();
         held_count = 0;
         sep_len    = LEN_RESET;
         sep_bytes  = SEP_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (fields_due.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual %0h/%b%b%b%b",
                        $time, rsp_mon.out_byte, rsp_mon.has_byte, rsp_mon.field_end,
                        rsp_mon.source_end, rsp_mon.run_last);
               mismatches++;
            end else begin
               want = fields_due.pop_front();
               check_field("out_byte", 64'(want.out_byte), 64'(rsp_mon.out_byte));
               check_field("has_byte", 64'(want.has_byte), 64'(rsp_mon.has_byte));
               check_field("field_end", 64'(want.field_end), 64'(rsp_mon.field_end));
               check_field("source_end", 64'(want.source_end), 64'(rsp_mon.source_end));
               check_field("run_last", 64'(want.run_last), 64'(rsp_mon.run_last));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            split_byte(req_mon.in_byte, req_mon.is_last);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[3] == CSR_IDX_SEP) begin
                  sep_bytes = pwdata;
               end else begin
                  sep_len = pwdata[LEN_W-1:0];
               end
            end else if (paddr[3] == CSR_IDX_SEP) begin
               check_field("separator_bytes", sep_bytes, prdata);
            end else begin
               check_field("separator_length", 64'(sep_len), prdata);
            end
         end
      end
      beats_due <= fields_due.size();
   end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// top of the separator splitter testbench: clock, reset, request and apb stimulus,
// response back-pressure and the verdict
// depends on mss_pkg, mss_if, multibyte_separator_splitter_core and mss_split_checker
`default_nettype none

module tb;
   import mss_pkg::*;

   localparam logic [PADDR_W-1:0] ADDR_LEN = {CSR_IDX_LEN, 3'b000};
   localparam logic [PADDR_W-1:0] ADDR_SEP = {CSR_IDX_SEP, 3'b000};
   localparam int RANDOM_ITEMS = 480;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 300;

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;
   int                 mismatches;
   int                 beats_due;
   int                 hold_asked;

   logic [LEN_W-1:0]   cur_len = LEN_RESET;
   logic [SEP_W-1:0]   cur_sep = SEP_RESET;
   bit                 gaps_on;
   bit                 narrow;
   int                 burst_left;
   int                 sent_count;

   mss_req_if req_ch ();
   mss_rsp_if rsp_ch ();

   multibyte_separator_splitter_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mss_split_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .mismatches (mismatches),
      .beats_due  (beats_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("multibyte_separator_splitter_core test failed");
      $finish;
   end

   // response side back-pressure
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      int mode;
      int mode_left;
      hold_left = 0;
      hold_seen = 0;
      mode      = 0;
      mode_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(3);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(1));
               2: rsp_ch.ready <= ($urandom_range(3) == 0);
               default: rsp_ch.ready <= (mode_left % 5 != 0);
            endcase
         end
      end
   end

   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic is_end);
      if (gaps_on && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.is_last <= is_end;
      do @(posedge clock); while (!req_ch.ready);
      if (burst_left > 0) begin
         burst_left--;
      end
      sent_count++;
   endtask

   // wait until every predicted beat is out, then let no-result bytes settle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic configure(input logic [LEN_W-1:0] len, input logic [SEP_W-1:0] sep);
      settle();
      csr_cycle(1'b1, ADDR_LEN, PDATA_W'(len));
      csr_cycle(1'b0, ADDR_LEN, '0);
      csr_cycle(1'b1, ADDR_SEP, sep);
      csr_cycle(1'b0, ADDR_SEP, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      cur_len = len;
      cur_sep = sep;
   endtask

   // mix of whole separators, broken prefixes, single separator bytes and noise bytes
   task automatic send_text(input int pieces, input bit terminate);
      logic [BYTE_W-1:0] text[$];
      int act;
      int n;
      act = int'(cur_len);
      if (act == 0) begin
         act = 1;
      end
      if (act > SEP_MAX_DEF) begin
         act = SEP_MAX_DEF;
      end
      for (int p = 0; p < pieces; p++) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               for (int k = 0; k < act; k++) begin
                  text.insert(text.size(), cur_sep[8*k +: 8]);
               end
            end
            3, 4: begin
               if (act > 1) begin
                  n = $urandom_range(1, act - 1);
                  for (int k = 0; k < n; k++) begin
                     text.insert(text.size(), cur_sep[8*k +: 8]);
                  end
               end else begin
                  text.insert(text.size(), 8'($urandom_range(255)));
               end
            end
            5: text.insert(text.size(), cur_sep[8*$urandom_range(act - 1) +: 8]);
            default: begin
               if (narrow) begin
                  text.insert(text.size(), 8'h61 + 8'($urandom_range(1)));
               end else begin
                  text.insert(text.size(), 8'($urandom_range(255)));
               end
            end
         endcase
      end
      foreach (text[i]) begin
         send_beat(text[i], terminate && (i == text.size() - 1));
      end
   endtask

   initial begin : stimulus
      int               directed_sent;
      int               phase;
      logic [LEN_W-1:0] len;
      logic [SEP_W-1:0] sep;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= '0;
      req_ch.is_last <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      hold_asked     <= 0;
      gaps_on    = 1'b0;
      narrow     = 1'b0;
      burst_left = 0;
      sent_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset separator is a comma of one byte
      send_beat("a", 1'b0);
      send_beat(",", 1'b0);
      send_beat("b", 1'b1);
      send_beat(",", 1'b1);
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      // held bytes compared against a changed separator
      configure(4'd3, 64'hFFFF_FFFF_FF63_6261);
      send_beat("a", 1'b0);
      send_beat("b", 1'b0);
      configure(4'd3, 64'h0000_0000_0071_6261);
      send_beat("q", 1'b1);
      // length lowered with bytes held
      send_beat("x", 1'b0);
      send_beat("a", 1'b0);
      send_beat("b", 1'b0);
      send_beat("c", 1'b0);
      send_beat("a", 1'b0);
      send_beat("b", 1'b0);
      configure(4'd1, 64'h62);
      send_beat("b", 1'b1);
      // length above the window size acts as the full window
      configure(4'd15, '1);
      for (int k = 0; k < 8; k++) begin
         send_beat(8'hFF, k == 7);
      end
      directed_sent = sent_count;

      phase = 0;
      while (sent_count < directed_sent + RANDOM_ITEMS) begin
         narrow = 1'b0;
         case (phase)
            0: begin
               len = 4'd0;
               sep = '0;
            end
            1: begin
               len = 4'd15;
               sep = '1;
            end
            2: begin
               len    = 4'd8;
               narrow = 1'b1;
            end
            3: begin
               len = 4'd1;
               sep = 64'hFF;
            end
            default: begin
               if ($urandom_range(5) == 0) begin
                  len = LEN_W'($urandom_range(15));
               end else begin
                  len = LEN_W'($urandom_range(1, 8));
               end
               narrow = ($urandom_range(2) == 0);
            end
         endcase
         if (phase == 2 || phase >= 4) begin
            sep = {32'($urandom), 32'($urandom)};
            if (narrow) begin
               for (int k = 0; k < 8; k++) begin
                  sep[8*k +: 8] = 8'h61 + 8'($urandom_range(1));
               end
            end
         end
         gaps_on = (phase % 3 != 1);
         configure(len, sep);
         if (phase == 4) begin
            gaps_on = 1'b0;
            hold_asked <= hold_asked + 1;
         end
         repeat ($urandom_range(3, 6)) begin
            send_text($urandom_range(1, 10), 1'b1);
         end
         if ($urandom_range(2) == 0) begin
            send_text($urandom_range(1, 4), 1'b0);
         end
         phase++;
      end

      settle();
      if (mismatches == 0) begin
         $display("multibyte_separator_splitter_core test passed");
      end else begin
         $display("multibyte_separator_splitter_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_if.sv
rtl/mss_csr.sv
rtl/mss_window.sv
rtl/mss_ctrl.sv
rtl/multibyte_separator_splitter_core.sv
rtl/mss_checker.sv
tb/sv/mss_split_checker.sv
tb/sv/tb.sv
